[src/pps_pkg.sv]
// ----------------------------------------------------------------------------
// pps_pkg
// Shared types, constants and tables of the phase-space histogram core.
// ----------------------------------------------------------------------------
package pps_pkg;

	localparam int NBINS_X_DEF  = 61;
	localparam int NBINS_Y_DEF  = 61;
	localparam int WEIGHTED_DEF = 1;

	localparam int DIM_W       = 6;
	localparam int HIST_ADDR_W = 2 * DIM_W;
	localparam int HIST_DEPTH  = 1 << HIST_ADDR_W;
	localparam int TOTAL_W     = 48;
	localparam int QUEUE_DEPTH = 2;
	localparam int CFG_IDX_W   = 3;
	localparam int CORDIC_STEPS = 23;

	localparam logic [31:0] Q_ONE  = 32'd65536;
	localparam logic signed [31:0] DEG90  = 32'sd5898240;
	localparam logic signed [31:0] DEG180 = 32'sd11796480;

	localparam logic [CFG_IDX_W-1:0] REG_SELECT_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SELECT_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_X    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH_X  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_Y    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH_Y  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MASS     = 3'd6;

	localparam logic [3:0] SEL_POS_X  = 4'd0;
	localparam logic [3:0] SEL_POS_Y  = 4'd1;
	localparam logic [3:0] SEL_POS_Z  = 4'd2;
	localparam logic [3:0] SEL_MOM_X  = 4'd3;
	localparam logic [3:0] SEL_MOM_Y  = 4'd4;
	localparam logic [3:0] SEL_MOM_Z  = 4'd5;
	localparam logic [3:0] SEL_GAMMA  = 4'd6;
	localparam logic [3:0] SEL_THETA  = 4'd7;
	localparam logic [3:0] SEL_ENERGY = 4'd8;

	typedef struct packed {
		logic [3:0]         select_x;
		logic [3:0]         select_y;
		logic signed [31:0] low_x;
		logic [30:0]        width_x;
		logic signed [31:0] low_y;
		logic [30:0]        width_y;
		logic [30:0]        mass_mev;
	} cfg_t;

	typedef struct packed {
		logic             is_read;
		logic [DIM_W-1:0] col;
		logic [DIM_W-1:0] row;
		logic [31:0]      add;
	} job_t;

	// atan(2^-i) in degrees, Q16.16
	function automatic logic signed [31:0] atan_deg(input logic [4:0] i);
		logic signed [31:0] a;
		unique case (i)
			5'd0:  a = 32'sd2949120;
			5'd1:  a = 32'sd1740967;
			5'd2:  a = 32'sd919879;
			5'd3:  a = 32'sd466945;
			5'd4:  a = 32'sd234379;
			5'd5:  a = 32'sd117304;
			5'd6:  a = 32'sd58666;
			5'd7:  a = 32'sd29335;
			5'd8:  a = 32'sd14668;
			5'd9:  a = 32'sd7334;
			5'd10: a = 32'sd3667;
			5'd11: a = 32'sd1833;
			5'd12: a = 32'sd917;
			5'd13: a = 32'sd458;
			5'd14: a = 32'sd229;
			5'd15: a = 32'sd115;
			5'd16: a = 32'sd57;
			5'd17: a = 32'sd29;
			5'd18: a = 32'sd14;
			5'd19: a = 32'sd7;
			5'd20: a = 32'sd4;
			5'd21: a = 32'sd2;
			5'd22: a = 32'sd1;
			default: a = 32'sd0;
		endcase
		return a;
	endfunction

endpackage

[src/particle_phase_space_histogram_core.sv]
// ----------------------------------------------------------------------------
// particle_phase_space_histogram_core
// Weighted (or counting) 2-D phase-space histogram: config, front, queue, back.
// ----------------------------------------------------------------------------
// Particle beat: 3 squares, a 32-step square root, normalization, 23 CORDIC
// steps and an 8-step bin division lead to the queue push; with zero transverse
// momentum CORDIC is skipped. The back then reads, updates and registers the bin.
// Read beat: goes straight to the push. One beat in the front at a time, next
// beat taken the cycle after the push. Reset: config and control registers take
// reset values; a clearing pass zeroes the histogram, in_ready low until it ends.
module particle_phase_space_histogram_core #(
	parameter int NBINS_X  = pps_pkg::NBINS_X_DEF,
	parameter int NBINS_Y  = pps_pkg::NBINS_Y_DEF,
	parameter int WEIGHTED = pps_pkg::WEIGHTED_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [pps_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [31:0]                    cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           func,
	input  logic signed [31:0]             pos_x,
	input  logic signed [31:0]             pos_y,
	input  logic signed [31:0]             pos_z,
	input  logic signed [31:0]             mom_x,
	input  logic signed [31:0]             mom_y,
	input  logic signed [31:0]             mom_z,
	input  logic [31:0]                    weight,
	input  logic [5:0]                     read_col,
	input  logic [5:0]                     read_row,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [5:0]                     bin_col,
	output logic [5:0]                     bin_row,
	output logic [47:0]                    bin_total
);
	import pps_pkg::*;

	cfg_t cfg_q;
	logic clear_done;
	logic fj_valid, fj_ready, q_valid, q_ready;
	job_t fj, qj;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.select_x <= 4'd0;
			cfg_q.select_y <= 4'd3;
			cfg_q.low_x    <= 32'sd0;
			cfg_q.width_x  <= 31'd65536;
			cfg_q.low_y    <= 32'sd0;
			cfg_q.width_y  <= 31'd65536;
			cfg_q.mass_mev <= 31'd33489;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SELECT_X: cfg_q.select_x <= cfg_data[3:0];
				REG_SELECT_Y: cfg_q.select_y <= cfg_data[3:0];
				REG_LOW_X:    cfg_q.low_x    <= $signed(cfg_data);
				REG_WIDTH_X:  cfg_q.width_x  <= cfg_data[30:0];
				REG_LOW_Y:    cfg_q.low_y    <= $signed(cfg_data);
				REG_WIDTH_Y:  cfg_q.width_y  <= cfg_data[30:0];
				REG_MASS:     cfg_q.mass_mev <= cfg_data[30:0];
				default: begin
				end
			endcase
		end
	end

	pps_front #(
		.NBINS_X  (NBINS_X),
		.NBINS_Y  (NBINS_Y),
		.WEIGHTED (WEIGHTED)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.enable    (clear_done),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.pos_z     (pos_z),
		.mom_x     (mom_x),
		.mom_y     (mom_y),
		.mom_z     (mom_z),
		.weight    (weight),
		.read_col  (read_col),
		.read_row  (read_row),
		.job_valid (fj_valid),
		.job_ready (fj_ready),
		.job       (fj)
	);

	pps_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fj_valid),
		.push_ready (fj_ready),
		.push_data  (fj),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_data   (qj)
	);

	pps_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_valid  (q_valid),
		.job_ready  (q_ready),
		.job        (qj),
		.clear_done (clear_done),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.bin_col    (bin_col),
		.bin_row    (bin_row),
		.bin_total  (bin_total)
	);

`ifndef SYNTHESIS
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!clear_done |-> !in_ready)
		else $error("input taken during clearing pass");
	a_front_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("front took a second beat while busy");
	a_back_pops_only_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(q_ready && q_valid) |=> !q_ready)
		else $error("back took two jobs back to back");
`endif

endmodule

[src/pps_ram.sv]
// ----------------------------------------------------------------------------
// pps_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pps_ram #(
	parameter int DATA_W = 48,
	parameter int DEPTH  = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DATA_W-1:0]        wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [DATA_W-1:0]        rdata
);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[src/pps_front.sv]
// ----------------------------------------------------------------------------
// pps_front
// Accepts beats; for particles derives gamma, theta, energy and bins both axes,
// reads use their own bin; hands a job (bin address, increment) to the queue.
// ----------------------------------------------------------------------------
module pps_front #(
	parameter int NBINS_X  = 61,
	parameter int NBINS_Y  = 61,
	parameter int WEIGHTED = 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  pps_pkg::cfg_t      cfg,
	input  logic               enable,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               func,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic signed [31:0] mom_x,
	input  logic signed [31:0] mom_y,
	input  logic signed [31:0] mom_z,
	input  logic [31:0]        weight,
	input  logic [5:0]         read_col,
	input  logic [5:0]         read_row,
	output logic               job_valid,
	input  logic               job_ready,
	output pps_pkg::job_t      job
);
	import pps_pkg::*;

	localparam logic [7:0] NBX = 8'(NBINS_X);
	localparam logic [7:0] NBY = 8'(NBINS_Y);

	typedef enum logic [11:0] {
		F_IDLE   = 12'b000000000001,
		F_SQ     = 12'b000000000010,
		F_SUM    = 12'b000000000100,
		F_SQRT   = 12'b000000001000,
		F_GAMMA  = 12'b000000010000,
		F_NORM   = 12'b000000100000,
		F_CORDIC = 12'b000001000000,
		F_THETA  = 12'b000010000000,
		F_SEL    = 12'b000100000000,
		F_CMP    = 12'b001000000000,
		F_DIV    = 12'b010000000000,
		F_PUSH   = 12'b100000000000
	} fstate_t;

	fstate_t state_q;
	logic [4:0] cnt_q;

	logic               func_q;
	logic signed [31:0] px_q, py_q, pz_q, mx_q, my_q, mz_q;
	logic [31:0]        weight_q;
	logic [5:0]         rc_q, rr_q;
	logic [62:0]        sqx_q, sqy_q, sqz_q;
	logic [63:0]        arga_q, argb_q;
	logic [33:0]        rema_q, remb_q;
	logic [31:0]        roota_q, rootb_q;
	logic [30:0]        g_q;
	logic [61:0]        eprod_q;
	logic signed [63:0] cx_q, cy_q;
	logic signed [31:0] cz_q, theta_q;
	logic signed [31:0] vx_q, vy_q;
	logic signed [40:0] upx_q, upy_q;
	logic               underx_q, undery_q, overx_q, overy_q;
	logic [32:0]        dx_q, dy_q;
	logic [7:0]         qx_q, qy_q;

	function automatic logic [31:0] mag32(input logic signed [31:0] v);
		return v[31] ? 32'(-v) : 32'(v);
	endfunction

	// one restoring square-root step: two radicand bits in, one root bit out
	function automatic logic [65:0] sqrt_step(input logic [33:0] rem,
		input logic [31:0] root, input logic [1:0] bits);
		logic [35:0] rsh;
		logic [35:0] trial;
		logic [65:0] res;
		rsh   = {rem, bits};
		trial = {2'b00, root, 2'b01};
		if (rsh >= trial) begin
			res = {34'(rsh - trial), root[30:0], 1'b1};
		end else begin
			res = {rsh[33:0], root[30:0], 1'b0};
		end
		return res;
	endfunction

	function automatic logic signed [31:0] quantity(input logic [3:0] sel,
		input logic signed [31:0] px, input logic signed [31:0] py,
		input logic signed [31:0] pz, input logic signed [31:0] mx,
		input logic signed [31:0] my, input logic signed [31:0] mz,
		input logic [30:0] g, input logic signed [31:0] th, input logic [30:0] e);
		logic signed [31:0] v;
		unique case (sel)
			SEL_POS_X:  v = px;
			SEL_POS_Y:  v = py;
			SEL_POS_Z:  v = pz;
			SEL_MOM_X:  v = mx;
			SEL_MOM_Y:  v = my;
			SEL_MOM_Z:  v = mz;
			SEL_GAMMA:  v = $signed({1'b0, g});
			SEL_THETA:  v = th;
			SEL_ENERGY: v = $signed({1'b0, e});
			default:    v = 32'sd0;
		endcase
		return v;
	endfunction

	function automatic logic [5:0] bin_of(input logic under, input logic over,
		input logic [7:0] q, input logic [7:0] nb);
		logic [8:0] b;
		if (under) begin
			b = 9'd0;
		end else if (over) begin
			b = 9'(nb) + 9'd2;
		end else begin
			b = 9'(q) + 9'd1;
		end
		return (b > 9'd63) ? 6'd63 : b[5:0];
	endfunction

	logic [31:0] mul_a;
	logic [63:0] mul_p;
	logic [65:0] step_a, step_b;
	logic [63:0] cmax;
	logic signed [63:0] shx, shy;
	logic [30:0] wx, wy, esat;
	logic [38:0] spanx, spany;
	logic [39:0] wshx, wshy;
	logic [30:0] gsat;
	logic [31:0] groot;

	always_comb begin
		unique case (cnt_q[1:0])
			2'd0:    mul_a = mag32(mx_q);
			2'd1:    mul_a = mag32(my_q);
			default: mul_a = mag32(mz_q);
		endcase
		mul_p  = 64'(mul_a) * 64'(mul_a);
		step_a = sqrt_step(rema_q, roota_q, arga_q[63:62]);
		step_b = sqrt_step(remb_q, rootb_q, argb_q[63:62]);
		groot  = rootb_q - Q_ONE;
		gsat   = groot[31] ? 31'h7FFF_FFFF : groot[30:0];
		cmax   = (cx_q > cy_q) ? cx_q : cy_q;
		shx    = cx_q >>> cnt_q;
		shy    = cy_q >>> cnt_q;
		esat   = (|eprod_q[61:47]) ? 31'h7FFF_FFFF : eprod_q[46:16];
		wx     = (cfg.width_x == 31'd0) ? 31'd1 : cfg.width_x;
		wy     = (cfg.width_y == 31'd0) ? 31'd1 : cfg.width_y;
		spanx  = 39'(wx) * 39'(NBX);
		spany  = 39'(wy) * 39'(NBY);
		wshx   = 40'(wx) << cnt_q[2:0];
		wshy   = 40'(wy) << cnt_q[2:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			cnt_q   <= 5'd0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (in_valid && in_ready) begin
						cnt_q   <= 5'd0;
						state_q <= func ? F_PUSH : F_SQ;
					end
				end
				F_SQ: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd2) begin
						state_q <= F_SUM;
					end
				end
				F_SUM: begin
					cnt_q   <= 5'd0;
					state_q <= F_SQRT;
				end
				F_SQRT: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) begin
						state_q <= F_GAMMA;
					end
				end
				F_GAMMA: state_q <= F_NORM;
				F_NORM: begin
					cnt_q <= 5'd0;
					if (roota_q == 32'd0) begin
						state_q <= F_THETA;
					end else if (cmax >= 64'h0800_0000_0000_0000) begin
						state_q <= F_CORDIC;
					end
				end
				F_CORDIC: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'(CORDIC_STEPS - 1)) begin
						state_q <= F_THETA;
					end
				end
				F_THETA: state_q <= F_SEL;
				F_SEL:   state_q <= F_CMP;
				F_CMP: begin
					cnt_q   <= 5'd7;
					state_q <= F_DIV;
				end
				F_DIV: begin
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == 5'd0) begin
						state_q <= F_PUSH;
					end
				end
				F_PUSH: begin
					if (job_ready) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			F_IDLE: begin
				if (in_valid && in_ready) begin
					func_q   <= func;
					px_q     <= pos_x;
					py_q     <= pos_y;
					pz_q     <= pos_z;
					mx_q     <= mom_x;
					my_q     <= mom_y;
					mz_q     <= mom_z;
					weight_q <= weight;
					rc_q     <= read_col;
					rr_q     <= read_row;
				end
			end
			F_SQ: begin
				unique case (cnt_q[1:0])
					2'd0:    sqx_q <= mul_p[62:0];
					2'd1:    sqy_q <= mul_p[62:0];
					default: sqz_q <= mul_p[62:0];
				endcase
			end
			F_SUM: begin
				arga_q  <= 64'(sqy_q) + 64'(sqz_q);
				argb_q  <= 64'h1_0000_0000 + 64'(sqx_q) + 64'(sqy_q) + 64'(sqz_q);
				rema_q  <= 34'd0;
				remb_q  <= 34'd0;
				roota_q <= 32'd0;
				rootb_q <= 32'd0;
			end
			F_SQRT: begin
				{rema_q, roota_q} <= step_a;
				{remb_q, rootb_q} <= step_b;
				arga_q <= {arga_q[61:0], 2'b00};
				argb_q <= {argb_q[61:0], 2'b00};
			end
			F_GAMMA: begin
				g_q  <= gsat;
				cx_q <= $signed({32'd0, mag32(mx_q)});
				cy_q <= $signed({32'd0, roota_q});
				cz_q <= 32'sd0;
			end
			F_NORM: begin
				eprod_q <= 62'(g_q) * 62'(cfg.mass_mev);
				if (cmax < 64'h0800_0000_0000_0000) begin
					// coarse step keeps the result below the target bit
					if (cmax < 64'h0008_0000_0000_0000) begin
						cx_q <= cx_q <<< 8;
						cy_q <= cy_q <<< 8;
					end else begin
						cx_q <= cx_q <<< 1;
						cy_q <= cy_q <<< 1;
					end
				end
			end
			F_CORDIC: begin
				if (!cy_q[63]) begin
					cx_q <= cx_q + shy;
					cy_q <= cy_q - shx;
					cz_q <= cz_q + atan_deg(cnt_q);
				end else begin
					cx_q <= cx_q - shy;
					cy_q <= cy_q + shx;
					cz_q <= cz_q - atan_deg(cnt_q);
				end
			end
			F_THETA: begin
				if (roota_q == 32'd0) begin
					theta_q <= mx_q[31] ? DEG180 : 32'sd0;
				end else if (cz_q < 32'sd0) begin
					theta_q <= mx_q[31] ? DEG180 : 32'sd0;
				end else if (cz_q > DEG90) begin
					theta_q <= DEG90;
				end else begin
					theta_q <= mx_q[31] ? DEG180 - cz_q : cz_q;
				end
			end
			F_SEL: begin
				vx_q  <= quantity(cfg.select_x, px_q, py_q, pz_q, mx_q, my_q, mz_q,
					g_q, theta_q, esat);
				vy_q  <= quantity(cfg.select_y, px_q, py_q, pz_q, mx_q, my_q, mz_q,
					g_q, theta_q, esat);
				upx_q <= 41'(cfg.low_x) + $signed({2'b00, spanx});
				upy_q <= 41'(cfg.low_y) + $signed({2'b00, spany});
			end
			F_CMP: begin
				underx_q <= vx_q < cfg.low_x;
				undery_q <= vy_q < cfg.low_y;
				overx_q  <= 41'(vx_q) > upx_q;
				overy_q  <= 41'(vy_q) > upy_q;
				dx_q     <= 33'(33'(vx_q) - 33'(cfg.low_x));
				dy_q     <= 33'(33'(vy_q) - 33'(cfg.low_y));
				qx_q     <= 8'd0;
				qy_q     <= 8'd0;
			end
			F_DIV: begin
				if (40'(dx_q) >= wshx) begin
					dx_q <= dx_q - wshx[32:0];
					qx_q[cnt_q[2:0]] <= 1'b1;
				end
				if (40'(dy_q) >= wshy) begin
					dy_q <= dy_q - wshy[32:0];
					qy_q[cnt_q[2:0]] <= 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign in_ready  = (state_q == F_IDLE) && enable;
	assign job_valid = (state_q == F_PUSH);

	always_comb begin
		job.is_read = func_q;
		job.add     = (WEIGHTED != 0) ? weight_q : Q_ONE;
		if (func_q) begin
			job.col = rc_q;
			job.row = rr_q;
		end else begin
			job.col = bin_of(underx_q, overx_q, qx_q, NBX);
			job.row = bin_of(undery_q, overy_q, qy_q, NBY);
		end
	end

endmodule

[src/pps_fifo.sv]
// ----------------------------------------------------------------------------
// pps_fifo
// Short job queue between the front and the histogram update side.
// ----------------------------------------------------------------------------
module pps_fifo #(
	parameter int DEPTH = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  pps_pkg::job_t push_data,
	output logic          pop_valid,
	input  logic          pop_ready,
	output pps_pkg::job_t pop_data
);
	import pps_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	job_t          mem_q [DEPTH];
	logic [PW-1:0] wptr_q, rptr_q;
	logic [CW-1:0] count_q;
	logic          do_push, do_pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= push_data;
		end
	end

endmodule

[src/pps_back.sv]
// ----------------------------------------------------------------------------
// pps_back
// Histogram side: clearing pass, read-modify-write of one bin per update job
// (read jobs only read it), output register.
// ----------------------------------------------------------------------------
module pps_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          job_valid,
	output logic          job_ready,
	input  pps_pkg::job_t job,
	output logic          clear_done,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [5:0]    bin_col,
	output logic [5:0]    bin_row,
	output logic [47:0]   bin_total
);
	import pps_pkg::*;

	localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

	typedef enum logic [2:0] {
		B_CLEAR  = 3'b001,
		B_IDLE   = 3'b010,
		B_UPDATE = 3'b100
	} bstate_t;

	bstate_t                state_q;
	logic [HIST_ADDR_W-1:0] clr_q;
	job_t                   job_q;
	logic                   out_valid_q;
	logic [DIM_W-1:0]       col_q, row_q;
	logic [TOTAL_W-1:0]     total_q;

	logic                   ram_we, ram_re;
	logic [HIST_ADDR_W-1:0] ram_waddr;
	logic [TOTAL_W-1:0]     ram_wdata, ram_rdata, updated;
	logic [TOTAL_W:0]       sum;

	pps_ram #(
		.DATA_W (TOTAL_W),
		.DEPTH  (HIST_DEPTH)
	) u_hist (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr ({job.col, job.row}),
		.rdata (ram_rdata)
	);

	assign job_ready = (state_q == B_IDLE) && !out_valid_q;
	assign ram_re    = job_valid && job_ready;

	always_comb begin
		sum     = {1'b0, ram_rdata} + (TOTAL_W + 1)'(job_q.add);
		updated = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
		if (state_q == B_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else begin
			ram_we    = (state_q == B_UPDATE) && !job_q.is_read;
			ram_waddr = {job_q.col, job_q.row};
			ram_wdata = updated;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				B_CLEAR: begin
					clr_q <= clr_q + HIST_ADDR_W'(1);
					if (clr_q == '1) begin
						state_q <= B_IDLE;
					end
				end
				B_IDLE: begin
					if (ram_re) begin
						state_q <= B_UPDATE;
					end
				end
				B_UPDATE: begin
					out_valid_q <= 1'b1;
					state_q     <= B_IDLE;
				end
				default: state_q <= B_CLEAR;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ram_re) begin
			job_q <= job;
		end
		if (state_q == B_UPDATE) begin
			col_q   <= job_q.col;
			row_q   <= job_q.row;
			total_q <= job_q.is_read ? ram_rdata : updated;
		end
	end

	assign clear_done = (state_q != B_CLEAR);
	assign out_valid  = out_valid_q;
	assign bin_col    = col_q;
	assign bin_row    = row_q;
	assign bin_total  = total_q;

endmodule
